// ===== src/bsr_pkg.sv =====
// ----------------------------------------------------------------------------
// bsr_pkg
// Shared types, constants and helpers for the x^7+x^4+1 bit scrambler with
// descrambler seed recovery.
// ----------------------------------------------------------------------------
`default_nettype none

package bsr_pkg;

  localparam int unsigned LFSR_W     = 7;
  localparam int unsigned SEED_LEN   = 7;
  localparam int unsigned TAIL_LEN   = 6;
  localparam int unsigned TAIL_OFST  = 16;
  localparam int unsigned POS_W      = 16;
  localparam int unsigned PLEN_W     = 12;
  localparam int unsigned CNT_W      = 3;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 7;

  localparam logic [LFSR_W-1:0] SEED_RESET = 7'd93;
  localparam logic [POS_W-1:0]  POS_MAX    = 16'hFFFF;
  localparam logic [POS_W-1:0]  TAIL_OFF   = 16'hFFFF;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SEED = 1'b1;

  // per-stream state carried between requests
  typedef struct packed {
    logic [LFSR_W-1:0] lfsr;
    logic              pass_mode;
    logic              collecting;
    logic [LFSR_W-1:0] seed_bits;
    logic [CNT_W-1:0]  seed_count;
    logic [POS_W-1:0]  bit_position;
    logic [POS_W-1:0]  tail_start;
  } bsr_state_t;

  // results caused by one request: zero, one or a burst of seven
  typedef struct packed {
    logic [CNT_W-1:0]    count;
    logic [SEED_LEN-1:0] bits;
    logic                seed_flag;
    logic [LFSR_W-1:0]   seed;
  } bsr_result_t;

  // seed that turns the seven buffered bits into zeros
  function automatic logic [LFSR_W-1:0] derive_seed(input logic [LFSR_W-1:0] d);
    logic [LFSR_W-1:0] s;
    s[0] = d[6] ^ d[2];
    s[1] = d[5] ^ d[1];
    s[2] = d[4] ^ d[0];
    s[3] = d[3] ^ s[0];
    s[4] = d[2] ^ s[1];
    s[5] = d[1] ^ s[2];
    s[6] = d[0] ^ s[3];
    return s;
  endfunction

endpackage

`default_nettype wire

// ===== src/bsr_step.sv =====
// ----------------------------------------------------------------------------
// bsr_step
// Next-state and result logic for one request: frame start handling, LFSR
// scrambling with tail zeroing, pass-through and descrambler seed recovery.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_step (
  input  bsr_pkg::bsr_state_t                   cur,
  input  logic                                  scramble_not_descramble,
  input  logic [bsr_pkg::LFSR_W-1:0]            frame_seed,
  input  logic                                  in_bit,
  input  logic                                  frame_start,
  input  logic                                  scramble_on,
  input  logic                                  tail_on,
  input  logic [bsr_pkg::PLEN_W-1:0]            payload_bytes,
  output bsr_pkg::bsr_state_t                   nxt,
  output bsr_pkg::bsr_result_t                  res
);
  import bsr_pkg::*;

  logic [POS_W-1:0]    pos;
  logic [POS_W:0]      tail_end;
  logic                in_tail;
  logic                fb;
  logic [LFSR_W-1:0]   sb;
  logic [LFSR_W-1:0]   sd;
  logic [LFSR_W-1:0]   l;
  logic                lfb;
  logic [SEED_LEN-1:0] burst;

  always_comb begin
    nxt = cur;
    res = '0;
    pos = '0;
    tail_end = '0;
    in_tail = 1'b0;
    sb = '0;
    sd = '0;
    l = '0;
    lfb = 1'b0;
    burst = '0;

    // frame start: restart position, pick mode for the frame
    if (frame_start) begin
      nxt.bit_position = '0;
      if (scramble_on) begin
        nxt.pass_mode = 1'b0;
        if (scramble_not_descramble) begin
          nxt.lfsr = frame_seed;
          nxt.tail_start = tail_on
            ? POS_W'({1'b0, payload_bytes, 3'b000}) + POS_W'(TAIL_OFST)
            : TAIL_OFF;
        end else begin
          nxt.collecting = 1'b1;
          nxt.seed_bits  = '0;
          nxt.seed_count = '0;
        end
      end else begin
        nxt.pass_mode = 1'b1;
      end
    end

    // saturating position counter
    pos = nxt.bit_position;
    if (pos != POS_MAX) nxt.bit_position = pos + POS_W'(1);

    fb = nxt.lfsr[3] ^ nxt.lfsr[6];

    tail_end = {1'b0, nxt.tail_start} + (POS_W+1)'(TAIL_LEN);
    in_tail = (nxt.tail_start != TAIL_OFF) && (pos >= nxt.tail_start)
              && ({1'b0, pos} < tail_end);

    if (nxt.pass_mode) begin
      res.count   = CNT_W'(1);
      res.bits[0] = in_bit;
    end else if (scramble_not_descramble) begin
      // scrambler, tail bits forced low
      nxt.lfsr    = {nxt.lfsr[LFSR_W-2:0], fb};
      res.count   = CNT_W'(1);
      res.bits[0] = in_tail ? 1'b0 : (in_bit ^ fb);
    end else if (nxt.collecting) begin
      sb = nxt.seed_bits;
      if (nxt.seed_count != CNT_W'(SEED_LEN)) sb[nxt.seed_count] = in_bit;
      if (nxt.seed_count < CNT_W'(SEED_LEN - 1)) begin
        nxt.seed_bits  = sb;
        nxt.seed_count = nxt.seed_count + CNT_W'(1);
      end else begin
        // seventh bit: recover seed and descramble the buffered bits
        sd = derive_seed(sb);
        l  = sd;
        for (int i = 0; i < SEED_LEN; i++) begin
          lfb      = l[3] ^ l[6];
          burst[i] = sb[i] ^ lfb;
          l        = {l[LFSR_W-2:0], lfb};
        end
        nxt.lfsr       = l;
        nxt.collecting = 1'b0;
        nxt.seed_count = '0;
        nxt.seed_bits  = '0;
        res.count      = CNT_W'(SEED_LEN);
        res.bits       = burst;
        res.seed_flag  = 1'b1;
        res.seed       = sd;
      end
    end else begin
      // descrambler after seed recovery
      nxt.lfsr    = {nxt.lfsr[LFSR_W-2:0], fb};
      res.count   = CNT_W'(1);
      res.bits[0] = in_bit ^ fb;
    end
  end

endmodule

`default_nettype wire

// ===== src/bit_scrambler_with_seed_recovery.sv =====
// A result appears on the output in the cycle after its request is taken.
// Throughput: one bit per cycle unless in_stall holds the input; the LFSR state
// updates in the input cycle. A seed recovery gives a burst of seven results
// from the output register; the input stalls while the burst drains.
// Reset (rst, synchronous) clears stream state, output queue and loads the
// configuration defaults (scrambler mode, seed 93).
// ----------------------------------------------------------------------------
// bit_scrambler_with_seed_recovery
// x^7+x^4+1 bit scrambler / descrambler with tail zeroing and seed recovery.
// ----------------------------------------------------------------------------
`default_nettype none

module bit_scrambler_with_seed_recovery (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [bsr_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [bsr_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_bit,
  input  logic                                 frame_start,
  input  logic                                 scramble_on,
  input  logic                                 tail_on,
  input  logic [bsr_pkg::PLEN_W-1:0]           payload_bytes,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic                                 out_bit,
  output logic                                 seed_valid,
  output logic [bsr_pkg::LFSR_W-1:0]           seed,
  output logic                                 last
);
  import bsr_pkg::*;

  logic                scramble_not_descramble;
  logic [LFSR_W-1:0]   frame_seed;
  bsr_state_t          state;
  bsr_state_t          state_next;
  bsr_result_t         res;

  // output queue: shift register of pending result bits
  logic [SEED_LEN-1:0] q_bits;
  logic [CNT_W-1:0]    q_cnt;
  logic                q_first;
  logic [LFSR_W-1:0]   q_seed;

  logic in_take;
  logic out_take;

  bsr_step u_step (
    .cur                     (state),
    .scramble_not_descramble (scramble_not_descramble),
    .frame_seed              (frame_seed),
    .in_bit                  (in_bit),
    .frame_start             (frame_start),
    .scramble_on             (scramble_on),
    .tail_on                 (tail_on),
    .payload_bytes           (payload_bytes),
    .nxt                     (state_next),
    .res                     (res)
  );

  // handshake
  assign out_take = out_valid && !out_stall;
  assign in_stall = !((q_cnt == '0) || ((q_cnt == CNT_W'(1)) && !out_stall));
  assign in_take  = in_valid && !in_stall;

  assign out_valid  = (q_cnt != '0);
  assign out_bit    = q_bits[0];
  assign seed_valid = q_first;
  assign seed       = q_first ? q_seed : '0;
  assign last       = (q_cnt == CNT_W'(1));

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      scramble_not_descramble <= 1'b1;
      frame_seed              <= SEED_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_MODE: scramble_not_descramble <= cfg_data[0];
        REG_SEED: frame_seed              <= cfg_data[LFSR_W-1:0];
        default:  ;
      endcase
    end
  end

  // stream state
  always_ff @(posedge clk) begin
    if (rst) begin
      state.lfsr         <= '0;
      state.pass_mode    <= 1'b0;
      state.collecting   <= 1'b0;
      state.seed_bits    <= '0;
      state.seed_count   <= '0;
      state.bit_position <= '0;
      state.tail_start   <= TAIL_OFF;
    end else if (in_take) begin
      state <= state_next;
    end
  end

  // result queue: load on request, shift on each result taken
  always_ff @(posedge clk) begin
    if (rst) begin
      q_cnt   <= '0;
      q_first <= 1'b0;
    end else if (in_take) begin
      q_cnt   <= res.count;
      q_first <= res.seed_flag;
    end else if (out_take) begin
      q_cnt   <= q_cnt - CNT_W'(1);
      q_first <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      q_bits <= res.bits;
      q_seed <= res.seed;
    end else if (out_take) begin
      q_bits <= {1'b0, q_bits[SEED_LEN-1:1]};
    end
  end

endmodule

`default_nettype wire

// ===== src/bsr_checker.sv =====
// ----------------------------------------------------------------------------
// bsr_checker
// Port-level checks for the scrambler: output hold, seed burst framing.
// ----------------------------------------------------------------------------
`default_nettype none

module bsr_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_stall,
  input logic                           out_bit,
  input logic                           seed_valid,
  input logic [bsr_pkg::LFSR_W-1:0]     seed,
  input logic                           last
);
  import bsr_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_bit) && $stable(last))
    else $error("stalled result changed");

  // seed flag opens a burst, never ends one
  a_seed_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && seed_valid |-> !last)
    else $error("seed flag on last result");

  // the burst continues right after the seed result is taken
  a_burst_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && seed_valid && !out_stall |=> out_valid && !seed_valid)
    else $error("seed burst broken");

  // seed field is zero unless flagged
  a_seed_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !seed_valid |-> seed == '0)
    else $error("seed field set without flag");

  // nothing pending after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result pending after reset");

endmodule

bind bit_scrambler_with_seed_recovery bsr_checker u_bsr_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .out_bit    (out_bit),
  .seed_valid (seed_valid),
  .seed       (seed),
  .last       (last)
);

`default_nettype wire
